// ----- rtl/cursor_alpha_overlay_unit_defines.svh -----
// Assertion helpers shared by the checker files of the cursor overlay unit.
// Every property is clocked on aclk and disabled while aresetn is low.
`ifndef CURSOR_ALPHA_OVERLAY_UNIT_DEFINES_SVH
`define CURSOR_ALPHA_OVERLAY_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAO_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CAO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cao_pkg.sv -----
`default_nettype none

package cao_pkg;

    // Default geometry of the frame and the cursor image.
    localparam int FRAME_WIDTH_DEF  = 640;
    localparam int FRAME_HEIGHT_DEF = 480;
    localparam int CURSOR_SIZE_DEF  = 32;

    // Fixed field widths.
    localparam int CFG_X_W     = 10;
    localparam int CFG_Y_W     = 9;
    localparam int IDX_W       = 10;
    localparam int CPIX_W      = 32;
    localparam int FPIX_W      = 16;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Command codes carried in the low bit of s_tuser.
    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_BLEND = 1'b1
    } cmd_t;

    // Register select, taken from bit 2 of the byte address.
    typedef enum logic {
        REG_CURSOR_X = 1'b0,
        REG_CURSOR_Y = 1'b1
    } reg_sel_t;

    // Control that travels with a blend item from the front end into the pipeline.
    typedef struct packed {
        logic valid;
        logic in_win;
    } stage_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/cursor_alpha_overlay_unit.sv -----
// Cursor overlay: blends a square BGRA cursor image over an RGB565 pixel stream.
// A blend item passes the store read stage and the sum stage into the output register.
// Throughput: one item per cycle while the result side takes items and no clearing pass
// runs; the store read and the blend stages are pipelined. Reset clears the counters
// and control registers, then a pass zeroes the cursor store while s_tready stays low.
`default_nettype none

module cursor_alpha_overlay_unit import cao_pkg::*; #(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
    parameter int CURSOR_SIZE  = CURSOR_SIZE_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input item.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [63:0]           s_tdata,  // cursor_index, cursor_pixel, frame_pixel, zero
    input  wire logic [1:0]            s_tuser,  // command, frame_start
    // Result item.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [15:0]           m_tdata,  // blended_pixel
    // Configuration.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int DEPTH = CURSOR_SIZE * CURSOR_SIZE;
    localparam int AW    = $clog2(DEPTH);

    logic [CFG_X_W-1:0] cursor_x_reg, cursor_x_next;
    logic [CFG_Y_W-1:0] cursor_y_reg, cursor_y_next;
    logic               cfg_wr;

    logic              mem_we, mem_re, s1_free;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [CPIX_W-1:0] mem_wdata, mem_rdata;
    stage_ctl_t        stage_ctl;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (cfg_wr) begin
            unique case (reg_sel_t'(paddr[2]))
                REG_CURSOR_X: cursor_x_next = pwdata[CFG_X_W-1:0];
                REG_CURSOR_Y: cursor_y_next = pwdata[CFG_Y_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end else begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_sel_t'(paddr[2]))
            REG_CURSOR_X: prdata = APB_DATA_W'(cursor_x_reg);
            REG_CURSOR_Y: prdata = APB_DATA_W'(cursor_y_reg);
            default:      prdata = '0;
        endcase
    end

    cao_ctrl #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .CURSOR_SIZE  (CURSOR_SIZE),
        .DEPTH        (DEPTH),
        .AW           (AW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .command      (s_tuser[0]),
        .frame_start  (s_tuser[1]),
        .cursor_index (s_tdata[9:0]),
        .cursor_pixel (s_tdata[41:10]),
        .cursor_x     (cursor_x_reg),
        .cursor_y     (cursor_y_reg),
        .s1_free      (s1_free),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .stage_out    (stage_ctl)
    );

    cao_ram #(
        .WIDTH (CPIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    cao_blend u_blend (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .stage_in      (stage_ctl),
        .pix_in        (s_tdata[57:42]),
        .mem_rdata     (mem_rdata),
        .s1_free       (s1_free),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .blended_pixel (m_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/cao_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module cao_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cao_ctrl.sv -----
`default_nettype none

// Front end: clearing pass, raster counters, window test and store access.
module cao_ctrl import cao_pkg::*; #(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
    parameter int CURSOR_SIZE  = CURSOR_SIZE_DEF,
    parameter int DEPTH        = CURSOR_SIZE * CURSOR_SIZE,
    parameter int AW           = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              command,
    input  wire logic              frame_start,
    input  wire logic [IDX_W-1:0]  cursor_index,
    input  wire logic [CPIX_W-1:0] cursor_pixel,
    input  wire logic [CFG_X_W-1:0] cursor_x,
    input  wire logic [CFG_Y_W-1:0] cursor_y,
    input  wire logic              s1_free,
    output logic                   mem_we,
    output logic      [AW-1:0]     mem_waddr,
    output logic      [CPIX_W-1:0] mem_wdata,
    output logic                   mem_re,
    output logic      [AW-1:0]     mem_raddr,
    output stage_ctl_t             stage_out
);

    localparam int COL_W = $clog2(FRAME_WIDTH);
    localparam int ROW_W = $clog2(FRAME_HEIGHT);
    localparam int CW    = ((COL_W > CFG_X_W) ? COL_W : CFG_X_W) + 1;
    localparam int RW    = ((ROW_W > CFG_Y_W) ? ROW_W : CFG_Y_W) + 1;
    localparam int IW    = ((IDX_W > AW) ? IDX_W : AW) + 1;
    localparam int CSW   = $clog2(CURSOR_SIZE);

    logic             clearing_reg, clearing_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic             accept, is_blend;
    logic [COL_W-1:0] col_base;
    logic [ROW_W-1:0] row_base;
    logic [CW-1:0]    dc_full;
    logic [RW-1:0]    dr_full;
    logic             in_col, in_row, idx_ok;
    logic [CSW-1:0]   dc, dr;

    assign s_tready = s1_free & ~clearing_reg;
    assign accept   = s_tvalid & s_tready;
    assign is_blend = (cmd_t'(command) == CMD_BLEND);

    // Position of this pixel; a frame start forces the top-left corner.
    assign col_base = frame_start ? '0 : col_reg;
    assign row_base = frame_start ? '0 : row_reg;

    // Window test against the cursor origin.
    assign dc_full = CW'(col_base) - CW'(cursor_x);
    assign dr_full = RW'(row_base) - RW'(cursor_y);
    assign in_col  = (CW'(col_base) >= CW'(cursor_x)) && (dc_full < CW'(CURSOR_SIZE));
    assign in_row  = (RW'(row_base) >= RW'(cursor_y)) && (dr_full < RW'(CURSOR_SIZE));
    assign dc      = dc_full[CSW-1:0];
    assign dr      = dr_full[CSW-1:0];

    assign idx_ok = (IW'(cursor_index) < IW'(DEPTH));

    // Store access: the clearing pass owns the write port until it ends.
    always_comb begin
        mem_re    = accept & is_blend;
        mem_raddr = AW'(AW'(dr) * AW'(CURSOR_SIZE) + AW'(dc));
        if (clearing_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = accept & ~is_blend & idx_ok;
            mem_waddr = AW'(cursor_index);
            mem_wdata = cursor_pixel;
        end
    end

    assign stage_out.valid  = accept & is_blend;
    assign stage_out.in_win = in_col & in_row;

    // Next state of the clearing pass and the raster counters.
    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clearing_next = 1'b0;
            end
        end
        if (accept && is_blend) begin
            if (col_base == COL_W'(FRAME_WIDTH - 1)) begin
                col_next = '0;
                row_next = (row_base == ROW_W'(FRAME_HEIGHT - 1)) ? '0 : row_base + 1'b1;
            end else begin
                col_next = col_base + 1'b1;
                row_next = row_base;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cao_blend.sv -----
`default_nettype none

// Blend pipeline: store data stage, weighted sums, divide by 255 into the output register.
module cao_blend import cao_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire stage_ctl_t        stage_in,
    input  wire logic [FPIX_W-1:0] pix_in,
    input  wire logic [CPIX_W-1:0] mem_rdata,
    output logic                   s1_free,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [FPIX_W-1:0] blended_pixel
);

    logic              v1_reg, v1_next, v2_reg, v2_next, ov_reg, ov_next;
    logic              win1_reg, win2_reg;
    logic [FPIX_W-1:0] pix1_reg, pix2_reg, out_reg;
    logic [13:0]       sb2_reg, sg2_reg, sr2_reg;
    logic              s2_free, o_free;

    logic [7:0]        alpha, alpha_inv;
    logic [13:0]       sb, sg, sr;
    logic [5:0]        qb, qg, qr;

    // Exact x/255 for x below 16320, where the quotient fits in six bits.
    function automatic logic [5:0] div255(input logic [13:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[13:8]) + 17'd1;
        return t[13:8];
    endfunction

    assign o_free  = ~ov_reg | m_tready;
    assign s2_free = ~v2_reg | o_free;
    assign s1_free = ~v1_reg | s2_free;

    // Weighted sums of the reduced cursor color and the frame color.
    assign alpha     = mem_rdata[7:0];
    assign alpha_inv = 8'd255 - alpha;
    assign sb = 14'(mem_rdata[31:27]) * 14'(alpha) + 14'(pix1_reg[15:11]) * 14'(alpha_inv);
    assign sg = 14'(mem_rdata[23:18]) * 14'(alpha) + 14'(pix1_reg[10:5]) * 14'(alpha_inv);
    assign sr = 14'(mem_rdata[15:11]) * 14'(alpha) + 14'(pix1_reg[4:0]) * 14'(alpha_inv);

    // Quotients of the registered sums.
    assign qb = div255(sb2_reg);
    assign qg = div255(sg2_reg);
    assign qr = div255(sr2_reg);

    // Occupancy of each stage.
    always_comb begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        ov_next = ov_reg;
        if (o_free) begin
            ov_next = v2_reg;
        end
        if (s2_free) begin
            v2_next = v1_reg;
        end
        if (s1_free) begin
            v1_next = stage_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            ov_reg <= ov_next;
        end
    end

    // Payload registers move with their stage.
    always_ff @(posedge aclk) begin
        if (s1_free) begin
            win1_reg <= stage_in.in_win;
            pix1_reg <= pix_in;
        end
        if (s2_free) begin
            win2_reg <= win1_reg;
            pix2_reg <= pix1_reg;
            sb2_reg  <= sb;
            sg2_reg  <= sg;
            sr2_reg  <= sr;
        end
        if (o_free) begin
            out_reg <= win2_reg ? {qb[4:0], qg, qr[4:0]} : pix2_reg;
        end
    end

    assign m_tvalid      = ov_reg;
    assign blended_pixel = out_reg;

endmodule

`default_nettype wire

// ----- rtl/cao_checker.sv -----
`default_nettype none

`include "cursor_alpha_overlay_unit_defines.svh"

// Port-level checks of the cursor overlay unit.
module cao_checker import cao_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [63:0]           s_tdata,
    input wire logic [1:0]            s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [15:0]           m_tdata,
    input wire logic                  psel,
    input wire logic                  penable,
    input wire logic                  pwrite,
    input wire logic [APB_ADDR_W-1:0] paddr,
    input wire logic [APB_DATA_W-1:0] pwdata,
    input wire logic [APB_DATA_W-1:0] prdata,
    input wire logic                  pready
);

    logic blend_acc;

    assign blend_acc = s_tvalid & s_tready & (cmd_t'(s_tuser[0]) == CMD_BLEND);

    // A stalled result holds.
    `CAO_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // Leaving reset, the store is being cleared and the pipeline is empty.
    `CAO_ASSERT_IMP(a_reset_state, $rose(aresetn), !s_tready && !m_tvalid, "bad state after reset")

    // With the output side taking items, an accepted blend item reaches the result port.
    `CAO_ASSERT_NEXT(a_latency, blend_acc ##1 m_tready ##1 m_tready, m_tvalid, "blend result missing")

    // The configuration port never waits.
    `CAO_ASSERT_IMP(a_pready, psel && penable, pready, "configuration access stalled")

endmodule

bind cursor_alpha_overlay_unit cao_checker u_checker (.*);

`default_nettype wire
